// ===== hw/rtl/rtc_pkg.sv =====
// ============================================================================
// rtc_pkg: shared types, constants and a function of the wall column unit
// Holds the channel payloads, the sequencer states, the divider control and
// the cosine polynomial used to fill the cosine table at elaboration.
// ============================================================================
`default_nettype none

package rtc_pkg;

    localparam int DEF_TEX_SIZE        = 64;
    localparam int DEF_COS_TABLE_DEPTH = 1024;
    localparam int DEF_POS_FRAC_BITS   = 16;

    localparam int COS_W      = 15;
    localparam int DIST_W     = 20;
    localparam int DEN_W      = 35;
    localparam int H8_W       = 24;
    localparam int DIV_CNT_W  = 6;
    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 22;
    localparam int MUL_P_W    = 48;
    localparam int STEP_EXT_W = 42;
    localparam int PROD_W     = 41;
    localparam int HALF_W     = 21;

    localparam logic [H8_W-1:0] H8_MAX = 24'hFFFFFF;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [1:0] REG_SCREEN_WIDTH        = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT       = 2'd1;
    localparam logic [1:0] REG_PROJECTION_DISTANCE = 2'd2;
    localparam logic [1:0] REG_PLAYER_ANGLE        = 2'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [11:0] column;
        logic [11:0] ray_angle;
        logic [19:0] ray_distance;
        logic [19:0] hit_x;
        logic [19:0] hit_y;
        logic        hit_side;
        logic [1:0]  wall_face;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  texture_select;
        logic [11:0] texel_address;
        logic [23:0] frame_address;
        logic        last_row;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROM,
        S_CORR,
        S_DIVH_START,
        S_DIVH,
        S_GEOM,
        S_DIVS,
        S_MUL_LO,
        S_MUL_HI
    } state_t;

    typedef enum logic [1:0] {
        MUL_CORR,
        MUL_LO,
        MUL_HI
    } mul_sel_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Cosine of a quarter-turn fraction xf (Q2.30), returned in Q1.14.
    function automatic logic [COS_W-1:0] cos_poly(input longint unsigned xf);
        longint unsigned th;
        longint unsigned t2;
        longint unsigned r;
        longint          c;
        th = (xf * HALF_PI_Q30) >> 30;
        t2 = (th * th) >> 30;
        r  = Q30_ONE;
        r  = Q30_ONE - ((t2 * r) >> 30) / 64'd90;
        r  = Q30_ONE - ((t2 * r) >> 30) / 64'd56;
        r  = Q30_ONE - ((t2 * r) >> 30) / 64'd30;
        r  = Q30_ONE - ((t2 * r) >> 30) / 64'd12;
        c  = longint'(Q30_ONE) - longint'(((t2 * r) >> 30) / 64'd2);
        if (c <= 0)
        begin
            c = 0;
        end
        else
        begin
            c = (c + 32768) >>> 16;
            if (c > 16384)
            begin
                c = 16384;
            end
        end
        return c[COS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtc_stream_if.sv =====
// ============================================================================
// rtc_stream_if: valid/ready channel
// Carries one payload per transaction from a source to a sink.
// ============================================================================
`default_nettype none

interface rtc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtc_cos_rom.sv =====
// ============================================================================
// rtc_cos_rom: cosine table
// Full-turn cosine in unsigned Q1.14, negative values held as zero,
// with a registered read port.
// ============================================================================
`default_nettype none

module rtc_cos_rom #(
    parameter int DEPTH = rtc_pkg::DEF_COS_TABLE_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    output logic [rtc_pkg::COS_W-1:0]       data
);

    logic [rtc_pkg::COS_W-1:0] rom [DEPTH];
    logic [rtc_pkg::COS_W-1:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        localparam longint unsigned Q4   = 4 * k;
        localparam longint unsigned QUAD = Q4 / DEPTH;
        localparam longint unsigned REM  = Q4 % DEPTH;
        localparam longint unsigned XF0  = (REM << 30) / DEPTH;
        localparam longint unsigned XF   = (QUAD == 3) ? rtc_pkg::Q30_ONE - XF0 : XF0;
        localparam logic [rtc_pkg::COS_W-1:0] VAL =
            (QUAD == 1 || QUAD == 2) ? '0 : rtc_pkg::cos_poly(XF);
        assign rom[k] = VAL;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rtc_divider.sv =====
// ============================================================================
// rtc_divider: shared restoring divider
// Produces one quotient bit per cycle from a preset partial remainder and a
// dividend shifted in most significant bit first.
// ============================================================================
`default_nettype none

module rtc_divider #(
    parameter int NUM_W = 31,
    parameter int QUO_W = 31
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rtc_pkg::div_ctrl_t          ctrl,
    input  wire logic [rtc_pkg::DEN_W-1:0]   den,
    input  wire logic [rtc_pkg::DEN_W-1:0]   rem_init,
    input  wire logic [NUM_W-1:0]            num_init,
    output rtc_pkg::div_stat_t               stat,
    output logic [QUO_W-1:0]                 quotient
);

    localparam int DW = rtc_pkg::DEN_W;

    logic [DW-1:0]                 rem_reg, rem_next;
    logic [DW-1:0]                 den_reg;
    logic [NUM_W-1:0]              num_reg;
    logic [QUO_W-1:0]              quo_reg;
    logic [rtc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [DW:0]                   shifted;
    logic                          fits;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[NUM_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? DW'(shifted - {1'b0, den_reg}) : shifted[DW-1:0];
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            cnt_next = ctrl.iters;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == rtc_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= rem_init;
            den_reg <= den;
            num_reg <= num_init;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/raycast_textured_wall_column_unit.sv =====
// ============================================================================
// raycast_textured_wall_column_unit: textured wall strip generator
// Turns one ray into a strip of texel and frame addresses, one per pixel.
// ============================================================================
// A load transaction (command 0) keeps the unit busy, with item.ready low, from
// S_ROM to S_MUL_HI; the time is set by the two divisions, height and texture
// step, which run one quotient bit per cycle on the shared restoring divider. A
// load gives no result. A pixel transaction (command 1) is answered from the
// output register while the strip has rows left, so pixels stream at one per
// cycle while the sink keeps up. The cosine table is a ROM filled at elaboration
// and needs no clearing pass after reset.
`default_nettype none

module raycast_textured_wall_column_unit #(
    parameter int TEX_SIZE        = rtc_pkg::DEF_TEX_SIZE,
    parameter int COS_TABLE_DEPTH = rtc_pkg::DEF_COS_TABLE_DEPTH,
    parameter int POS_FRAC_BITS   = rtc_pkg::DEF_POS_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rtc_stream_if.sink       item,
    rtc_stream_if.source     result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int TC_W       = $clog2(TEX_SIZE);
    localparam int IDX_W      = $clog2(COS_TABLE_DEPTH);
    localparam int IDX_PROD_W = 12 + $clog2(COS_TABLE_DEPTH + 1);
    localparam int STEP_SHIFT = TC_W + POS_FRAC_BITS + 8;
    localparam int SW         = STEP_SHIFT + 1;
    localparam int QW         = (SW > rtc_pkg::H8_W) ? SW : rtc_pkg::H8_W;
    localparam int DW         = rtc_pkg::DEN_W;

    // Configuration registers.
    logic [12:0] sw_reg, sh_reg;
    logic [19:0] pd_reg;
    logic [11:0] pa_reg;
    logic        cfg_wr;

    // Strip state.
    logic [11:0]      strip_column_reg;
    logic [11:0]      current_row_reg;
    logic [12:0]      rows_left_reg;
    logic [31:0]      tex_pos_reg;
    logic [31:0]      tex_step_reg;
    logic [TC_W-1:0]  tex_col_reg;
    logic [1:0]       face_held_reg;

    // Load working registers.
    logic [11:0]                 lcol_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [19:0]                 dist_reg;
    logic [9:0]                  frac_reg;
    logic [1:0]                  face_reg;
    logic [rtc_pkg::H8_W-1:0]    h8_reg;
    logic [11:0]                 top_reg;
    logic [12:0]                 rows_reg;
    logic [25:0]                 w_reg;
    logic [SW-1:0]               step_reg;
    logic signed [rtc_pkg::MUL_P_W-1:0] mul_reg;

    logic                   out_valid_reg, out_valid_next;
    rtc_pkg::out_item_t     out_item_reg;
    rtc_pkg::state_t        state_reg, state_next;

    // Sequencer strobes.
    rtc_pkg::mul_sel_t  mul_sel;
    rtc_pkg::div_ctrl_t div_ctrl;
    rtc_pkg::div_stat_t div_stat;
    logic               accept_ok;
    logic               corr_en, h8_sat_en, h8_div_en, geom_en;
    logic               step_zero_en, step_div_en, mul_lo_en, commit_en;
    logic [DW-1:0]      div_den, div_rem_init;
    logic [SW-1:0]      div_num_init;
    logic [QW-1:0]      quotient;

    logic item_fire, load_fire, pix_fire, pix_emit;
    logic [rtc_pkg::COS_W-1:0] cos_q;
    logic [11:0]               angle_diff;
    logic [IDX_PROD_W-1:0]     idx_prod;
    logic [DW-1:0]             corr;
    logic                      h8_sat;
    logic [12:0]               hgt;
    logic [11:0]               centre;
    logic [20:0]               c512;
    logic                      above;
    logic [11:0]               top_c;
    logic [16:0]               rows_a;
    logic [12:0]               lim;
    logic [12:0]               rows_c;
    logic [25:0]               w_c;
    logic [rtc_pkg::STEP_EXT_W-1:0] step_ext;
    logic signed [rtc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [rtc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [rtc_pkg::MUL_P_W-1:0] mul_p;
    logic [rtc_pkg::PROD_W-1:0]         prod;
    logic [TC_W-1:0]                    trow;
    logic [24:0]                        frame_full;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 13'd640;
            sh_reg <= 13'd480;
            pd_reg <= 20'd554;
            pa_reg <= 12'd0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                rtc_pkg::REG_SCREEN_WIDTH:        sw_reg <= pwdata[12:0];
                rtc_pkg::REG_SCREEN_HEIGHT:       sh_reg <= pwdata[12:0];
                rtc_pkg::REG_PROJECTION_DISTANCE: pd_reg <= pwdata[19:0];
                rtc_pkg::REG_PLAYER_ANGLE:        pa_reg <= pwdata[11:0];
                default:                          sw_reg <= sw_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            rtc_pkg::REG_SCREEN_WIDTH:        prdata = 32'(sw_reg);
            rtc_pkg::REG_SCREEN_HEIGHT:       prdata = 32'(sh_reg);
            rtc_pkg::REG_PROJECTION_DISTANCE: prdata = 32'(pd_reg);
            rtc_pkg::REG_PLAYER_ANGLE:        prdata = 32'(pa_reg);
            default:                          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign item.ready = (state_reg == rtc_pkg::S_IDLE) && accept_ok;
    assign item_fire  = item.valid && item.ready;
    assign load_fire  = item_fire && (item.payload.command == rtc_pkg::CMD_LOAD);
    assign pix_fire   = item_fire && (item.payload.command == rtc_pkg::CMD_PIXEL);
    assign pix_emit   = pix_fire && (rows_left_reg != '0);

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtc_pkg::S_IDLE:
            begin
                if (load_fire)
                begin
                    state_next = rtc_pkg::S_ROM;
                end
            end
            rtc_pkg::S_ROM:       state_next = rtc_pkg::S_CORR;
            rtc_pkg::S_CORR:      state_next = rtc_pkg::S_DIVH_START;
            rtc_pkg::S_DIVH_START:
            begin
                state_next = h8_sat ? rtc_pkg::S_GEOM : rtc_pkg::S_DIVH;
            end
            rtc_pkg::S_DIVH:
            begin
                if (div_stat.done)
                begin
                    state_next = rtc_pkg::S_GEOM;
                end
            end
            rtc_pkg::S_GEOM:
            begin
                state_next = (h8_reg == '0) ? rtc_pkg::S_MUL_LO : rtc_pkg::S_DIVS;
            end
            rtc_pkg::S_DIVS:
            begin
                if (div_stat.done)
                begin
                    state_next = rtc_pkg::S_MUL_LO;
                end
            end
            rtc_pkg::S_MUL_LO:    state_next = rtc_pkg::S_MUL_HI;
            rtc_pkg::S_MUL_HI:    state_next = rtc_pkg::S_IDLE;
            default:              state_next = rtc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        accept_ok      = !out_valid_reg || result.ready;
        mul_sel        = rtc_pkg::MUL_CORR;
        div_ctrl.start = 1'b0;
        div_ctrl.iters = rtc_pkg::DIV_CNT_W'(rtc_pkg::H8_W);
        div_den        = corr;
        div_rem_init   = DW'({pd_reg, 4'b0});
        div_num_init   = '0;
        corr_en        = 1'b0;
        h8_sat_en      = 1'b0;
        h8_div_en      = 1'b0;
        geom_en        = 1'b0;
        step_zero_en   = 1'b0;
        step_div_en    = 1'b0;
        mul_lo_en      = 1'b0;
        commit_en      = 1'b0;
        case (state_reg)
            rtc_pkg::S_CORR:
            begin
                corr_en = 1'b1;
            end
            rtc_pkg::S_DIVH_START:
            begin
                h8_sat_en      = h8_sat;
                div_ctrl.start = !h8_sat;
            end
            rtc_pkg::S_DIVH:
            begin
                h8_div_en = div_stat.done;
            end
            rtc_pkg::S_GEOM:
            begin
                geom_en        = 1'b1;
                step_zero_en   = (h8_reg == '0);
                div_ctrl.start = (h8_reg != '0);
                div_ctrl.iters = rtc_pkg::DIV_CNT_W'(SW);
                div_den        = DW'(h8_reg);
                div_rem_init   = '0;
                div_num_init   = SW'(1) << STEP_SHIFT;
            end
            rtc_pkg::S_DIVS:
            begin
                step_div_en = div_stat.done;
            end
            rtc_pkg::S_MUL_LO:
            begin
                mul_sel   = rtc_pkg::MUL_LO;
                mul_lo_en = 1'b1;
            end
            rtc_pkg::S_MUL_HI:
            begin
                mul_sel   = rtc_pkg::MUL_HI;
                commit_en = 1'b1;
            end
            default:
            begin
                mul_sel = rtc_pkg::MUL_CORR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    rtc_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .clk  (clk),
        .addr (idx_reg),
        .data (cos_q)
    );

    rtc_divider #(
        .NUM_W (SW),
        .QUO_W (QW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .den      (div_den),
        .rem_init (div_rem_init),
        .num_init (div_num_init),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign step_ext = rtc_pkg::STEP_EXT_W'(step_reg);

    always_comb
    begin
        case (mul_sel)
            rtc_pkg::MUL_CORR:
            begin
                mul_a = $signed(rtc_pkg::MUL_A_W'(dist_reg));
                mul_b = $signed(rtc_pkg::MUL_B_W'(cos_q));
            end
            rtc_pkg::MUL_LO:
            begin
                mul_a = $signed(w_reg);
                mul_b = $signed({1'b0, step_ext[rtc_pkg::HALF_W-1:0]});
            end
            rtc_pkg::MUL_HI:
            begin
                mul_a = $signed(w_reg);
                mul_b = $signed({1'b0, step_ext[rtc_pkg::STEP_EXT_W-1:rtc_pkg::HALF_W]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Column geometry
    // ------------------------------------------------------------------
    always_comb
    begin
        angle_diff = item.payload.ray_angle - pa_reg;
        idx_prod   = IDX_PROD_W'(angle_diff) * IDX_PROD_W'(COS_TABLE_DEPTH);
        corr       = mul_reg[DW-1:0];
        h8_sat     = (corr == '0) || (DW'({pd_reg, 4'b0}) >= corr);
        hgt        = (sh_reg > 13'd4096) ? 13'd4096 : sh_reg;
        centre     = hgt[12:1];
        c512       = {centre, 9'b0};
        above      = {3'b0, c512} > h8_reg;
        top_c      = above ? 12'(({3'b0, c512} - h8_reg) >> 9) : 12'd0;
        rows_a     = 17'((25'(h8_reg) + 25'd255) >> 8);
        lim        = hgt - 13'(top_c);
        rows_c     = (rows_a > 17'(lim)) ? lim : 13'(rows_a);
        w_c        = 26'({top_c, 9'b0}) - 26'(c512) + 26'(h8_reg);
        prod       = mul_reg[rtc_pkg::PROD_W-1:0]
                     + {mul_p[rtc_pkg::PROD_W-rtc_pkg::HALF_W-1:0],
                        {rtc_pkg::HALF_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            lcol_reg <= item.payload.column;
            idx_reg  <= idx_prod[12 +: IDX_W];
            dist_reg <= item.payload.ray_distance;
            frac_reg <= item.payload.hit_side ? item.payload.hit_y[9:0]
                                              : item.payload.hit_x[9:0];
            face_reg <= item.payload.wall_face;
        end
        if (corr_en || mul_lo_en)
        begin
            mul_reg <= mul_p;
        end
        if (h8_sat_en)
        begin
            h8_reg <= rtc_pkg::H8_MAX;
        end
        else if (h8_div_en)
        begin
            h8_reg <= quotient[rtc_pkg::H8_W-1:0];
        end
        if (geom_en)
        begin
            top_reg  <= top_c;
            rows_reg <= rows_c;
            w_reg    <= w_c;
        end
        if (step_zero_en)
        begin
            step_reg <= '0;
        end
        else if (step_div_en)
        begin
            step_reg <= quotient[SW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Strip state and pixel output
    // ------------------------------------------------------------------
    assign trow       = tex_pos_reg[POS_FRAC_BITS +: TC_W];
    assign frame_full = 25'(current_row_reg) * 25'(sw_reg) + 25'(strip_column_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_column_reg <= '0;
            current_row_reg  <= '0;
            rows_left_reg    <= '0;
            tex_pos_reg      <= '0;
            tex_step_reg     <= '0;
            tex_col_reg      <= '0;
            face_held_reg    <= '0;
        end
        else if (commit_en)
        begin
            strip_column_reg <= lcol_reg;
            current_row_reg  <= top_reg;
            rows_left_reg    <= rows_reg;
            tex_pos_reg      <= prod[rtc_pkg::PROD_W-1:9];
            tex_step_reg     <= 32'(step_reg);
            tex_col_reg      <= frac_reg[9 -: TC_W];
            face_held_reg    <= face_reg;
        end
        else if (pix_emit)
        begin
            current_row_reg <= current_row_reg + 12'd1;
            rows_left_reg   <= rows_left_reg - 13'd1;
            tex_pos_reg     <= tex_pos_reg + tex_step_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pix_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_emit)
        begin
            out_item_reg.texture_select <= face_held_reg;
            out_item_reg.texel_address  <= 12'({trow, tex_col_reg});
            out_item_reg.frame_address  <= frame_full[23:0];
            out_item_reg.last_row       <= (rows_left_reg == 13'd1);
        end
    end

`ifndef SYNTHESIS
    a_rows_count: assert property (@(posedge clk) disable iff (!rst_n)
        pix_emit |=> rows_left_reg == $past(rows_left_reg) - 13'd1)
        else $error("rows left did not count down on an emitted pixel");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        pix_emit |=> result.valid
                     && (result.payload.last_row == ($past(rows_left_reg) == 13'd1)))
        else $error("last row flag does not match the strip end");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == rtc_pkg::S_DIVH || state_reg == rtc_pkg::S_DIVS))
        else $error("divider finished outside a division state");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> state_reg == rtc_pkg::S_ROM && !item.ready)
        else $error("load transaction did not start the sequencer");
`endif

endmodule

`default_nettype wire

// ===== sim/raycast_textured_wall_column_unit_test.sv =====
// ============================================================================
// raycast_textured_wall_column_unit_test: wall strip generator testbench
// Loads rays and requests pixels through the valid/ready channels and
// reprograms the screen, projection and view angle registers between phases over APB.
// An internal strip predictor works out every texel and frame address, and
// each result transaction is compared with the oldest prediction.
// ============================================================================
`default_nettype none

module raycast_textured_wall_column_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int TEX_SIZE      = 64;
    localparam int COS_DEPTH     = 1024;
    localparam int POS_FRAC_BITS = 16;
    localparam int TEX_COL_W     = $clog2(TEX_SIZE);
    localparam int LOAD_LATENCY  = 80;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 200;

    localparam longint unsigned Q30_UNIT    = 64'd1073741824;
    localparam longint unsigned QUARTER_Q30 = 64'd1686629713;
    localparam longint unsigned HEIGHT_CAP  = 64'hFFFFFF;

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;
    localparam logic       SIDE_X     = 1'b0;
    localparam logic       SIDE_Y     = 1'b1;

    class wall_strip_predictor;
        logic [14:0]          cos_rom [COS_DEPTH];
        logic [12:0]          scr_width;
        logic [12:0]          scr_height;
        logic [19:0]          proj_dist;
        logic [11:0]          view_angle;
        logic [11:0]          strip_col;
        logic [11:0]          row_now;
        logic [12:0]          rows_left;
        logic [31:0]          tex_pos;
        logic [31:0]          tex_step;
        logic [TEX_COL_W-1:0] tex_col;
        logic [1:0]           face;
        rtc_pkg::out_item_t   pending_pixels[$];
        int                   errors;
        int                   pixels_checked;
        int                   loads_seen;
        int                   pixel_requests;

        function new();
            for (int k = 0; k < COS_DEPTH; k++)
            begin
                cos_rom[k] = cos_entry(k);
            end
            scr_width  = 13'd640;
            scr_height = 13'd480;
            proj_dist  = 20'd554;
            view_angle = '0;
            strip_col  = '0;
            row_now    = '0;
            rows_left  = '0;
            tex_pos    = '0;
            tex_step   = '0;
            tex_col    = '0;
            face       = '0;
        endfunction

        function logic [14:0] cos_entry(int k);
            longint unsigned q;
            longint unsigned quad;
            longint unsigned rem;
            longint unsigned xf;
            longint unsigned th;
            longint unsigned t2;
            longint unsigned r;
            longint          c;
            int              divs [4] = '{90, 56, 30, 12};
            q    = longint'(k) * 4;
            quad = q / COS_DEPTH;
            rem  = q % COS_DEPTH;
            if (quad == 1 || quad == 2)
            begin
                return '0;
            end
            xf = (rem << 30) / COS_DEPTH;
            if (quad == 3)
            begin
                xf = Q30_UNIT - xf;
            end
            th = (xf * QUARTER_Q30) >> 30;
            t2 = (th * th) >> 30;
            r  = Q30_UNIT;
            foreach (divs[i])
            begin
                r = Q30_UNIT - ((t2 * r) >> 30) / divs[i];
            end
            c = longint'(Q30_UNIT) - longint'(((t2 * r) >> 30) / 2);
            if (c <= 0)
            begin
                return '0;
            end
            c = (c + 32768) >>> 16;
            if (c > 16384)
            begin
                c = 16384;
            end
            return c[14:0];
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        function void set_register(logic [1:0] index, logic [31:0] value);
            case (index)
                rtc_pkg::REG_SCREEN_WIDTH:        scr_width  = value[12:0];
                rtc_pkg::REG_SCREEN_HEIGHT:       scr_height = value[12:0];
                rtc_pkg::REG_PROJECTION_DISTANCE: proj_dist  = value[19:0];
                rtc_pkg::REG_PLAYER_ANGLE:        view_angle = value[11:0];
                default:                          ;
            endcase
        endfunction

        function void load_ray(rtc_pkg::in_item_t it);
            logic [11:0]     diff;
            longint unsigned idx;
            longint unsigned ray_dist;
            longint unsigned corr;
            longint unsigned pd;
            longint unsigned h8;
            longint unsigned hgt;
            longint unsigned centre;
            longint unsigned top;
            longint unsigned rows;
            longint unsigned step;
            longint unsigned frac;
            longint          w;
            longint          start;
            diff     = it.ray_angle - view_angle;
            idx      = diff;
            idx      = (idx * COS_DEPTH) >> 12;
            ray_dist = it.ray_distance;
            corr     = ray_dist * cos_rom[idx];
            pd       = proj_dist;
            hgt      = (scr_height > 13'd4096) ? 4096 : scr_height;
            centre   = hgt >> 1;
            if (corr == 0)
            begin
                h8 = HEIGHT_CAP;
            end
            else
            begin
                h8 = (pd << 28) / corr;
                if (h8 > HEIGHT_CAP)
                begin
                    h8 = HEIGHT_CAP;
                end
            end
            top  = (centre * 512 > h8) ? ((centre * 512 - h8) >> 9) : 0;
            rows = (h8 + 255) >> 8;
            if (rows > hgt - top)
            begin
                rows = hgt - top;
            end
            if (h8 == 0)
            begin
                step  = 0;
                start = 0;
            end
            else
            begin
                step  = (longint'(TEX_SIZE) << (POS_FRAC_BITS + 8)) / h8;
                w     = longint'(top * 512) - longint'(centre * 512) + longint'(h8);
                start = (w * longint'(step)) >>> 9;
            end
            frac      = (it.hit_side == SIDE_Y) ? it.hit_y[9:0] : it.hit_x[9:0];
            strip_col = it.column;
            row_now   = top[11:0];
            rows_left = rows[12:0];
            tex_step  = step[31:0];
            tex_pos   = start[31:0];
            tex_col   = TEX_COL_W'((frac * TEX_SIZE) >> 10);
            face      = it.wall_face;
        endfunction

        function void next_pixel();
            rtc_pkg::out_item_t want;
            longint unsigned    trow;
            longint unsigned    taddr;
            longint unsigned    faddr;
            if (rows_left == 0)
            begin
                return;
            end
            trow  = (tex_pos >> POS_FRAC_BITS) & (TEX_SIZE - 1);
            taddr = trow * TEX_SIZE + tex_col;
            faddr = row_now;
            faddr = faddr * scr_width + strip_col;
            want.texture_select = face;
            want.texel_address  = taddr[11:0];
            want.frame_address  = faddr[23:0];
            want.last_row       = (rows_left == 1);
            pending_pixels.push_back(want);
            tex_pos   = tex_pos + tex_step;
            row_now   = row_now + 12'd1;
            rows_left = rows_left - 13'd1;
        endfunction

        function void accept_item(rtc_pkg::in_item_t it);
            if (it.command == rtc_pkg::CMD_LOAD)
            begin
                loads_seen++;
                load_ray(it);
            end
            else
            begin
                pixel_requests++;
                next_pixel();
            end
        endfunction

        task check_pixel(rtc_pkg::out_item_t got);
            rtc_pkg::out_item_t want;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("result with none expected: frame %0h texel %0h",
                                 got.frame_address, got.texel_address));
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.texture_select !== want.texture_select)
            begin
                report($sformatf("texture_select got %0d want %0d at frame %0h",
                                 got.texture_select, want.texture_select, want.frame_address));
            end
            if (got.texel_address !== want.texel_address)
            begin
                report($sformatf("texel_address got %0h want %0h at frame %0h",
                                 got.texel_address, want.texel_address, want.frame_address));
            end
            if (got.frame_address !== want.frame_address)
            begin
                report($sformatf("frame_address got %0h want %0h",
                                 got.frame_address, want.frame_address));
            end
            if (got.last_row !== want.last_row)
            begin
                report($sformatf("last_row got %0b want %0b at frame %0h",
                                 got.last_row, want.last_row, want.frame_address));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rtc_stream_if #(.payload_t(rtc_pkg::in_item_t))  item_ch ();
    rtc_stream_if #(.payload_t(rtc_pkg::out_item_t)) result_ch ();

    wall_strip_predictor sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int settings_applied;
    int cycle_count;

    raycast_textured_wall_column_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                sb.check_pixel(result_ch.payload);
            end
            if (hold_request != 0)
            begin
                stall_left = hold_request;
                hold_request <= 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic rtc_pkg::in_item_t random_item();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(rtc_pkg::in_item_t)-1:0];
    endfunction

    function automatic rtc_pkg::in_item_t pixel_item();
        rtc_pkg::in_item_t it;
        it         = random_item();
        it.command = rtc_pkg::CMD_PIXEL;
        return it;
    endfunction

    function automatic rtc_pkg::in_item_t ray(int col, int ang, int distance, int hx, int hy,
                                              logic side, logic [1:0] face);
        rtc_pkg::in_item_t it;
        it              = '0;
        it.command      = rtc_pkg::CMD_LOAD;
        it.column       = 12'(col);
        it.ray_angle    = 12'(ang);
        it.ray_distance = 20'(distance);
        it.hit_x        = 20'(hx);
        it.hit_y        = 20'(hy);
        it.hit_side     = side;
        it.wall_face    = face;
        return it;
    endfunction

    // Most rays aim at a wall height between one row and about twice the screen height.
    function automatic rtc_pkg::in_item_t make_ray();
        rtc_pkg::in_item_t it;
        longint unsigned   d;
        int                h;
        int                pick;
        it         = random_item();
        it.command = rtc_pkg::CMD_LOAD;
        if ($urandom_range(0, 99) < 70)
        begin
            it.ray_angle = 12'(int'(sb.view_angle) + int'($urandom_range(0, 1400)) - 700);
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            it.ray_distance = '0;
        end
        else if (pick >= 25)
        begin
            h = $urandom_range(1, 2 * sb.scr_height + 2);
            d = sb.proj_dist;
            d = (d * 64) / h + $urandom_range(0, 63);
            it.ray_distance = (d > 64'hFFFFF) ? 20'hFFFFF : d[19:0];
        end
        return it;
    endfunction

    task send(rtc_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        sb.accept_item(it);
    endtask

    task wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task apb_write(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.set_register(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // A load gives no result, so the divider may still be busy once drained.
    task apply_setting(int sw, int sh, int pd, int pa);
        wait_drained();
        repeat (LOAD_LATENCY) @(posedge clk);
        apb_write(rtc_pkg::REG_SCREEN_WIDTH, sw);
        apb_write(rtc_pkg::REG_SCREEN_HEIGHT, sh);
        apb_write(rtc_pkg::REG_PROJECTION_DISTANCE, pd);
        apb_write(rtc_pkg::REG_PLAYER_ANGLE, pa);
        settings_applied++;
    endtask

    task set_idle(int mode);
        case (mode)
            0:       begin send_idle_pct = 21; recv_idle_pct = 59; end
            1:       begin send_idle_pct = 59; recv_idle_pct = 21; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    task run_random(int count);
        int sent;
        int npix;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send(make_ray());
                sent++;
                npix = sb.rows_left;
                if (npix > 40)
                begin
                    npix = $urandom_range(1, 40);
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    npix = $urandom_range(0, npix);
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    npix = npix + $urandom_range(1, 2);
                end
                repeat (npix)
                begin
                    send(pixel_item());
                    sent++;
                end
            end
            else
            begin
                send(random_item());
                sent++;
            end
        end
    endtask

    task directed_items();
        send(pixel_item());
        send(ray(4095, 0, 16384, 20'hFFFFF, 0, SIDE_X, FACE_WEST));
        repeat (4) send(pixel_item());
        send(ray(0, 4095, 0, 0, 20'hFFFFF, SIDE_Y, FACE_NORTH));
        repeat (2) send(pixel_item());
        send(ray(2047, 2048, 20'hFFFFF, 20'h003FF, 20'hFFC00, SIDE_X, FACE_SOUTH));
        send(pixel_item());
        send(ray(100, 3000, 20'hFFFFF, 20'h00200, 20'h00155, SIDE_X, FACE_EAST));
        repeat (3) send(pixel_item());
        send(ray(320, 1024, 4096, 0, 512, SIDE_Y, FACE_SOUTH));
        send(pixel_item());
        send(ray(321, 512, 4096, 0, 512, SIDE_Y, FACE_EAST));
        repeat (5) send(pixel_item());
    endtask

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        item_ch.valid    = 1'b0;
        item_ch.payload  = '0;
        hold_request     = 0;
        cycle_count      = 0;
        settings_applied = 0;
        set_idle(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        apply_setting(1, 1, 0, 4095);
        run_random(60);
        apply_setting(4096, 4096, 1048575, 2048);
        run_random(80);
        set_idle(1);
        apply_setting(640, 0, 554, 100);
        run_random(40);
        apply_setting(1000, 6000, 20000, 3000);
        run_random(60);

        for (int p = 0; p < 6; p++)
        begin
            apply_setting($urandom_range(1, 4096), $urandom_range(8, 200),
                          $urandom_range(16, 4000), $urandom_range(0, 4095));
            set_idle(p / 2);
            if (p == 2)
            begin
                run_random(100);
                wait_drained();
                run_random(100);
            end
            else
            begin
                run_random(200);
            end
        end

        // The sink stalls while a tall strip keeps pixel requests coming.
        apply_setting(800, 300, 2000, 0);
        set_idle(2);
        hold_request <= LONG_HOLD;
        send(ray(400, 0, 0, 20'h12345, 0, SIDE_X, FACE_NORTH));
        repeat (80) send(pixel_item());
        run_random(100);

        wait_drained();
        repeat (LOAD_LATENCY) @(posedge clk);
        $display("covered %0d ray loads and %0d pixel requests under %0d register settings",
                 sb.loads_seen, sb.pixel_requests, settings_applied + 1);
        $display("checked %0d pixel results, %0d mismatches", sb.pixels_checked, sb.errors);
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/rtc_pkg.sv
hw/rtl/rtc_stream_if.sv
hw/rtl/rtc_cos_rom.sv
hw/rtl/rtc_divider.sv
hw/rtl/raycast_textured_wall_column_unit.sv
sim/raycast_textured_wall_column_unit_test.sv
